[sv/ceq_pkg.sv]
// ceq_pkg: shared types and codes for the coalescing event queue.
// Used by ceq_store, ceq_seq and coalescing_event_queue; depends on nothing.
package ceq_pkg;

  // Default number of queue entries.
  localparam int CEQ_DEPTH = 1024;

  // Packed input stream width (fields plus zero fill to whole bytes).
  localparam int IN_TDATA_W = 152;
  // Bits of a returned event on the output stream, before the fill count.
  localparam int OUT_EVENT_W = 149;

  // Reset value of the motion kind register.
  localparam logic [4:0] MOTION_KIND_RST = 5'd1;

  // Request codes; any code other than push or pop acts as a peek.
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  typedef enum logic [2:0] {
    STS_APPENDED  = 3'd0,
    STS_COALESCED = 3'd1,
    STS_DROPPED   = 3'd2,
    STS_POPPED    = 3'd3,
    STS_PEEKED    = 3'd4,
    STS_EMPTY     = 3'd5
  } sts_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_RESP
  } state_t;

  // One queued event.
  typedef struct packed {
    logic [31:0] detail;
    logic [15:0] height;
    logic [15:0] width;
    logic [15:0] root_y;
    logic [15:0] root_x;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [15:0] window;
    logic [4:0]  kind;
  } entry_t;

  // Pending result of one item.
  typedef struct packed {
    sts_t   status;
    entry_t ev;
  } res_t;

endpackage

[sv/ceq_store.sv]
// ceq_store: event storage, one write port and one registered read port.
// Depends on ceq_pkg for entry_t.
module ceq_store
  import ceq_pkg::*;
#(
  parameter int DEPTH = CEQ_DEPTH,
  localparam int PW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [PW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [PW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ceq_seq.sv]
// ceq_seq: request sequencer, ring pointers, occupancy and the shared
// compare unit that walks the queue for coalescing. Depends on ceq_pkg.
module ceq_seq
  import ceq_pkg::*;
#(
  parameter int DEPTH = CEQ_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  // request
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    req_type,
  input  entry_t        req_ev,
  input  logic          req_compress,
  // motion kind register
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [4:0]    cfg_data,
  // storage
  output logic          mem_we,
  output logic [PW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic          mem_re,
  output logic [PW-1:0] mem_raddr,
  input  entry_t        mem_q,
  // result
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic [CW-1:0] res_fill
);

  state_t        state_r, state_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [PW-1:0] iss_r, iss_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    reqt_r, reqt_nxt;
  entry_t        req_r, req_nxt;
  res_t          res_r, res_nxt;
  logic [4:0]    motion_r, motion_nxt;
  logic          full;
  logic          eligible;
  logic          hit;
  entry_t        merged;

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full     = (occ_r == CW'(DEPTH));
  assign eligible = (req_ev.kind == motion_r) && (req_ev.window != 16'd0) && req_compress;
  assign hit      = (mem_q.kind == motion_r) && (mem_q.window == req_r.window);

  // Stored entry with only its local position replaced
  always_comb begin
    merged       = mem_q;
    merged.pos_x = req_r.pos_x;
    merged.pos_y = req_r.pos_y;
  end

  // Next state and storage control
  always_comb begin
    state_nxt  = state_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    occ_nxt    = occ_r;
    iss_nxt    = iss_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    reqt_nxt   = reqt_r;
    req_nxt    = req_r;
    res_nxt    = res_r;
    motion_nxt = cfg_valid ? cfg_data : motion_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wr_ptr_r;
    mem_wdata  = req_r;
    mem_re     = 1'b0;
    mem_raddr  = iss_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt  = req_ev;
          reqt_nxt = req_type;
          res_nxt  = '{status: STS_EMPTY, ev: '0};
          if (req_type == REQ_PUSH) begin
            if (full) begin
              res_nxt.status = STS_DROPPED;
              state_nxt      = S_RESP;
            end else if (eligible && (occ_r != '0)) begin
              // start the walk at the oldest entry
              mem_re    = 1'b1;
              mem_raddr = rd_ptr_r;
              iss_nxt   = wrap_next(rd_ptr_r);
              cur_nxt   = rd_ptr_r;
              cnt_nxt   = '0;
              state_nxt = S_SCAN;
            end else begin
              mem_we         = 1'b1;
              mem_wdata      = req_ev;
              wr_ptr_nxt     = wrap_next(wr_ptr_r);
              occ_nxt        = occ_r + CW'(1);
              res_nxt.status = STS_APPENDED;
              state_nxt      = S_RESP;
            end
          end else if (occ_r == '0) begin
            state_nxt = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rd_ptr_r;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        res_nxt.ev = mem_q;
        if (reqt_r == REQ_POP) begin
          res_nxt.status = STS_POPPED;
          rd_ptr_nxt     = wrap_next(rd_ptr_r);
          occ_nxt        = occ_r - CW'(1);
        end else begin
          res_nxt.status = STS_PEEKED;
        end
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        // keep one read in flight ahead of the compare
        mem_re    = 1'b1;
        mem_raddr = iss_r;
        iss_nxt   = wrap_next(iss_r);
        cur_nxt   = wrap_next(cur_r);
        cnt_nxt   = cnt_r + CW'(1);
        if (hit) begin
          mem_we         = 1'b1;
          mem_waddr      = cur_r;
          mem_wdata      = merged;
          res_nxt.status = STS_COALESCED;
          state_nxt      = S_RESP;
        end else if (cnt_r + CW'(1) == occ_r) begin
          // no match anywhere: append
          mem_we         = 1'b1;
          wr_ptr_nxt     = wrap_next(wr_ptr_r);
          occ_nxt        = occ_r + CW'(1);
          res_nxt.status = STS_APPENDED;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      occ_r    <= '0;
      motion_r <= MOTION_KIND_RST;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      occ_r    <= occ_nxt;
      motion_r <= motion_nxt;
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    iss_r  <= iss_nxt;
    cur_r  <= cur_nxt;
    cnt_r  <= cnt_nxt;
    reqt_r <= reqt_nxt;
    req_r  <= req_nxt;
    res_r  <= res_nxt;
  end

  assign cfg_ready = 1'b1;
  assign res       = res_r;
  assign res_fill  = occ_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above queue depth");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + CW'(1)) ||
                     (occ_r + CW'(1) == $past(occ_r)))
    else $error("occupancy moved by more than one");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r < occ_r))
    else $error("walk ran past the stored entries");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (req_type == REQ_PUSH) && full) |=>
      ((state_r == S_RESP) && (res_r.status == STS_DROPPED)))
    else $error("push into full queue not dropped");
`endif

endmodule

[sv/coalescing_event_queue.sv]
// Path to out_tvalid: S_RESP, then the output register; a pop/peek of an entry
//   passes S_READ first, a walking push S_SCAN over k (1..occupancy) entries.
// Throughput: one item at a time; the walk compares one stored entry per cycle on
//   the single read port.
// Reset: pointers and occupancy clear, motion kind goes to 1, storage is not cleared.
module coalescing_event_queue
  import ceq_pkg::*;
#(
  parameter int QUEUE_DEPTH = CEQ_DEPTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((OUT_EVENT_W + CW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, low bit up: event_kind, window_id, compress_motion, pos_x, pos_y,
  //   root_x, root_y, width, height, detail, zero fill
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]            in_tuser,   // req_type
  // configuration: motion_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [4:0]            cfg_data,
  // out_tdata, low bit up: out_kind, out_window, out_x, out_y, out_root_x,
  //   out_root_y, out_width, out_height, out_detail, fill_count, zero fill
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  output logic [2:0]            out_tuser   // status
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        req_ev;
  logic          req_compress;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  entry_t        mem_q;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic [CW-1:0] res_fill;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [2:0]    out_user_r, out_user_nxt;

  // Unpack the input item
  always_comb begin
    req_ev.kind   = in_tdata[4:0];
    req_ev.window = in_tdata[20:5];
    req_compress  = in_tdata[21];
    req_ev.pos_x  = in_tdata[37:22];
    req_ev.pos_y  = in_tdata[53:38];
    req_ev.root_x = in_tdata[69:54];
    req_ev.root_y = in_tdata[85:70];
    req_ev.width  = in_tdata[101:86];
    req_ev.height = in_tdata[117:102];
    req_ev.detail = in_tdata[149:118];
  end

  ceq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  ceq_seq #(.DEPTH(QUEUE_DEPTH)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req_type     (in_tuser),
    .req_ev       (req_ev),
    .req_compress (req_compress),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_q        (mem_q),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .res_fill     (res_fill)
  );

  // Take a result whenever the output slot is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = res.status;
      out_data_nxt  = OUT_W'({res_fill, res.ev.detail, res.ev.height, res.ev.width,
                              res.ev.root_y, res.ev.root_x, res.ev.pos_y, res.ev.pos_x,
                              res.ev.window, res.ev.kind});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
